>>> sv/ecgd_pkg.sv
package ecgd_pkg;

    // Lane count and field widths
    localparam int CHANNELS  = 4;
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = SAMPLE_W + 1;
    localparam int RATIO_W   = 10;
    localparam int WEIGHT_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int HOLD_W    = 4;
    localparam int AVG_W     = 33;
    localparam int SUMW_W    = SUM_W + WEIGHT_W;
    localparam int KEEP_W    = WEIGHT_W + 1;
    localparam int DECAY_W   = AVG_W + KEEP_W;
    localparam int THR_W     = AVG_W + RATIO_W;
    localparam int SUM_FRAC  = 24;
    localparam int RATE_W    = 16;
    localparam int MAG_W     = RATE_W + 1;
    localparam int MPROD_W   = MAG_W + GAIN_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Stream widths: tdata padded to whole bytes
    localparam int IN_FIELDS = 2 * CHANNELS + 2;
    localparam int IN_RAW_W  = IN_FIELDS * SAMPLE_W;
    localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W = 4 + 2 * RATE_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // Constants
    localparam logic [KEEP_W-1:0]  WEIGHT_ONE = KEEP_W'(1) << WEIGHT_W;
    localparam logic [AVG_W-1:0]   AVG_RESET  = AVG_W'(10000) << 16;
    localparam logic [RATIO_W-1:0] RATIO_RST  = RATIO_W'(461);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(655);
    localparam logic [GAIN_W-1:0]  GAIN_RST   = GAIN_W'(9830);
    localparam logic [HOLD_W-1:0]  HOLD_RST   = HOLD_W'(3);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO  = 2'd0,
        CFG_WEIGHT = 2'd1,
        CFG_GAIN   = 2'd2,
        CFG_HOLD   = 2'd3
    } t_cfg_idx;

    // Pipeline load strobes shared by lanes and cursor path
    typedef struct packed {
        logic load1;
        logic load2;
    } t_pipe_ctrl;

endpackage

>>> sv/ecgd_lane.sv
module ecgd_lane (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ecgd_pkg::t_pipe_ctrl     i_ctrl,
    input  logic [15:0]              i_sample_a,
    input  logic [15:0]              i_sample_b,
    input  logic [15:0]              i_weight,
    input  logic [9:0]               i_ratio,
    output logic                     o_pass
);
    import ecgd_pkg::*;

    logic [SUM_W-1:0]   c_sum;
    logic [SUMW_W-1:0]  c_sumw;
    logic [SUM_W-1:0]   r_sum1;
    logic [SUMW_W-1:0]  r_sumw1;
    logic [KEEP_W-1:0]  c_keep;
    logic [DECAY_W-1:0] c_decay;
    logic [AVG_W-1:0]   n_avg;
    logic [AVG_W-1:0]   r_avg;
    logic [THR_W-1:0]   c_thr;
    logic [THR_W-1:0]   r_thr;
    logic [SUM_W-1:0]   r_sum2;

    // Stage 1: sample sum and its weighted share
    assign c_sum  = SUM_W'(i_sample_a) + SUM_W'(i_sample_b);
    assign c_sumw = SUMW_W'(c_sum) * SUMW_W'(i_weight);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load1) begin
            r_sum1  <= c_sum;
            r_sumw1 <= c_sumw;
        end
    end

    // Stage 2: threshold product and average recurrence
    assign c_keep  = WEIGHT_ONE - KEEP_W'(i_weight);
    assign c_decay = DECAY_W'(r_avg) * DECAY_W'(c_keep);
    assign n_avg   = AVG_W'((c_decay >> 16) + DECAY_W'(r_sumw1));
    assign c_thr   = THR_W'(r_avg) * THR_W'(i_ratio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= AVG_RESET;
        end else if (i_ctrl.load2) begin
            r_avg <= n_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load2) begin
            r_thr  <= c_thr;
            r_sum2 <= r_sum1;
        end
    end

    // Channel passes when sum (scaled to Q.24) reaches the threshold
    assign o_pass = (THR_W'({r_sum2, SUM_FRAC'(0)}) >= r_thr);

endmodule

>>> sv/ecgd_cursor.sv
module ecgd_cursor (
    input  logic                  i_clk,
    input  ecgd_pkg::t_pipe_ctrl  i_ctrl,
    input  logic signed [15:0]    i_pitch_rate,
    input  logic signed [15:0]    i_yaw_rate,
    input  logic [15:0]           i_gain,
    output logic signed [15:0]    o_move_x,
    output logic signed [15:0]    o_move_y
);
    import ecgd_pkg::*;

    logic [1:0][RATE_W-1:0]  c_rate;
    logic [1:0][MAG_W-1:0]   c_mag;
    logic [1:0][MPROD_W-1:0] c_prod;
    logic [1:0][RATE_W-1:0]  r_q1;
    logic [1:0]              r_neg1;
    logic [1:0][RATE_W-1:0]  r_move;

    // Element 0 is pitch (vertical), element 1 is yaw (horizontal)
    assign c_rate[0] = i_pitch_rate;
    assign c_rate[1] = i_yaw_rate;

    // Stage 1: magnitude times gain, truncated
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            c_mag[k]  = c_rate[k][RATE_W-1] ? (MAG_W'(1) << RATE_W) - MAG_W'(c_rate[k])
                                            : MAG_W'(c_rate[k]);
            c_prod[k] = MPROD_W'(c_mag[k]) * MPROD_W'(i_gain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load1) begin
            for (int k = 0; k < 2; k++) begin
                r_q1[k]   <= c_prod[k][GAIN_W +: RATE_W];
                r_neg1[k] <= c_rate[k][RATE_W-1];
            end
        end
    end

    // Stage 2: restore sign
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load2) begin
            for (int k = 0; k < 2; k++) begin
                r_move[k] <= r_neg1[k] ? (RATE_W'(0) - r_q1[k]) : r_q1[k];
            end
        end
    end

    assign o_move_y = r_move[0];
    assign o_move_x = r_move[1];

endmodule

>>> sv/emg_click_gesture_detector_unit.sv
// EMG click gesture detector: accepts one sensor frame per clock while the output is not
// stalled and returns one result per frame through the stage-1, stage-2 and output registers.
// Throughput is set by the per-channel average update, a single-register multiply-add loop, so
// frames may stream back to back. Four channel lanes run side by side; their pass flags are
// combined in the output stage, which also runs the press/release hold counter. Gyro rates
// are scaled into cursor deltas alongside. Configuration writes take effect at once and are
// meant for idle periods.
module emg_click_gesture_detector_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // ch0_a, ch0_b, ch1_a, ch1_b, ch2_a, ch2_b, ch3_a, ch3_b, pitch_rate, yaw_rate (LSB up)
    input  logic [ecgd_pkg::IN_W-1:0]     s_axis_tdata,
    // master stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // press_event, release_event, button_held, move_valid, move_x, move_y, zero pad (LSB up)
    output logic [ecgd_pkg::OUT_W-1:0]    m_axis_tdata,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ecgd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ecgd_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import ecgd_pkg::*;

    logic [RATIO_W-1:0]  r_ratio;
    logic [WEIGHT_W-1:0] r_weight;
    logic [GAIN_W-1:0]   r_gain;
    logic [HOLD_W-1:0]   r_rel_frames;

    logic r_v1, r_v2, r_v3;
    logic c_rdy1, c_rdy2, c_rdy3;
    logic c_load3;
    t_pipe_ctrl c_ctrl;

    logic [CHANNELS-1:0] c_pass;
    logic signed [RATE_W-1:0] c_move_x, c_move_y;

    logic              c_active;
    logic              n_press, n_release;
    logic [HOLD_W-1:0] n_hold;
    logic [HOLD_W-1:0] r_hold;
    logic              r_press, r_release, r_held, r_move_valid;
    logic [RATE_W-1:0] r_move_x, r_move_y;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio      <= RATIO_RST;
            r_weight     <= WEIGHT_RST;
            r_gain       <= GAIN_RST;
            r_rel_frames <= HOLD_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RATIO:  r_ratio      <= i_cfg_data[RATIO_W-1:0];
                CFG_WEIGHT: r_weight     <= i_cfg_data[WEIGHT_W-1:0];
                CFG_GAIN:   r_gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_HOLD:   r_rel_frames <= i_cfg_data[HOLD_W-1:0];
            endcase
        end
    end

    // Pipeline flow control: each stage loads when its successor frees up
    assign c_rdy3        = !r_v3 || m_axis_tready;
    assign c_rdy2        = !r_v2 || c_rdy3;
    assign c_rdy1        = !r_v1 || c_rdy2;
    assign s_axis_tready = c_rdy1;
    assign c_ctrl.load1  = s_axis_tvalid && c_rdy1;
    assign c_ctrl.load2  = r_v1 && c_rdy2;
    assign c_load3       = r_v2 && c_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (c_ctrl.load1)      r_v1 <= 1'b1;
            else if (c_ctrl.load2) r_v1 <= 1'b0;
            if (c_ctrl.load2)      r_v2 <= 1'b1;
            else if (c_load3)      r_v2 <= 1'b0;
            if (c_load3)           r_v3 <= 1'b1;
            else if (m_axis_tready) r_v3 <= 1'b0;
        end
    end

    // Channel lanes
    for (genvar n = 0; n < CHANNELS; n++) begin : g_lane
        ecgd_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (c_ctrl),
            .i_sample_a (s_axis_tdata[(2*n)*SAMPLE_W +: SAMPLE_W]),
            .i_sample_b (s_axis_tdata[(2*n+1)*SAMPLE_W +: SAMPLE_W]),
            .i_weight   (r_weight),
            .i_ratio    (r_ratio),
            .o_pass     (c_pass[n])
        );
    end

    // Cursor path
    ecgd_cursor u_cursor (
        .i_clk        (i_clk),
        .i_ctrl       (c_ctrl),
        .i_pitch_rate (s_axis_tdata[(2*CHANNELS)*SAMPLE_W +: RATE_W]),
        .i_yaw_rate   (s_axis_tdata[(2*CHANNELS+1)*SAMPLE_W +: RATE_W]),
        .i_gain       (r_gain),
        .o_move_x     (c_move_x),
        .o_move_y     (c_move_y)
    );

    // Merge: all lanes must pass, then press/release hold logic
    assign c_active = &c_pass;

    always_comb begin
        n_press   = 1'b0;
        n_release = 1'b0;
        n_hold    = r_hold;
        if (c_active && (r_hold == '0)) begin
            n_press = 1'b1;
            n_hold  = r_rel_frames;
        end else if (!c_active && (r_hold != '0)) begin
            n_hold    = r_hold - HOLD_W'(1);
            n_release = (n_hold == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= '0;
        end else if (c_load3) begin
            r_hold <= n_hold;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (c_load3) begin
            r_press      <= n_press;
            r_release    <= n_release;
            r_held       <= (n_hold != '0);
            r_move_valid <= (c_move_x != '0) || (c_move_y != '0);
            r_move_x     <= c_move_x;
            r_move_y     <= c_move_y;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = OUT_W'({r_move_y, r_move_x, r_move_valid, r_held,
                                   r_release, r_press});

`ifndef NO_ASSERTIONS
    // Press and release are mutually exclusive
    a_press_xor_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> !(r_press && r_release))
        else $error("press and release in the same frame");

    // A release always leaves the button up
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_release) |-> !r_held)
        else $error("release issued while button still held");

    // Hold counter only moves when a frame enters the output stage
    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(c_load3) |-> $stable(r_hold))
        else $error("hold counter changed without a frame");

    // A press reloads the counter from the release setting
    a_press_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_load3 && n_press) |=> (r_hold == $past(r_rel_frames)))
        else $error("press did not load hold counter");
`endif

endmodule

>>> bench/emg_click_gesture_detector_unit_tb.sv
`timescale 1ns / 100ps

module emg_click_gesture_detector_unit_tb;

    import ecgd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_SUM        = 131070;
    localparam int PHASE_FRAMES   = 470;

    // One sensor frame, laid out exactly as s_axis_tdata (ch0_sample_a in the lowest bits)
    typedef struct packed {
        logic signed [RATE_W-1:0]               yaw;
        logic signed [RATE_W-1:0]               pitch;
        logic [CHANNELS-1:0][1:0][SAMPLE_W-1:0] samples;
    } t_frame;

    // One result, laid out exactly as m_axis_tdata
    typedef struct packed {
        logic [OUT_W-OUT_RAW_W-1:0] pad;
        logic signed [RATE_W-1:0]   move_y;
        logic signed [RATE_W-1:0]   move_x;
        logic                       move_valid;
        logic                       button_held;
        logic                       release_event;
        logic                       press_event;
    } t_click_result;

    typedef enum {FR_QUIET, FR_CLICK, FR_BOUNDARY, FR_ONE_LOW, FR_NOISE} t_frame_kind;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    // ch0_a, ch0_b, ch1_a, ch1_b, ch2_a, ch2_b, ch3_a, ch3_b, pitch_rate, yaw_rate (LSB up)
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b1;
    // press_event, release_event, button_held, move_valid, move_x, move_y, pad (LSB up)
    wire  [OUT_W-1:0]     m_axis_tdata;
    logic                 i_cfg_we      = 1'b0;
    t_cfg_idx             i_cfg_idx     = CFG_RATIO;
    logic [CFG_DAT_W-1:0] i_cfg_data    = '0;

    // Detector state and register copies
    logic [AVG_W-1:0]    avg_model [CHANNELS];
    logic [HOLD_W-1:0]   hold_model;
    logic [RATIO_W-1:0]  ratio_cfg;
    logic [WEIGHT_W-1:0] weight_cfg;
    logic [GAIN_W-1:0]   gain_cfg;
    logic [HOLD_W-1:0]   hold_cfg;

    t_click_result expected_results [$];
    int errors        = 0;
    int frames_sent   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_cycles   = 0;

    emg_click_gesture_detector_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: cycles without any transfer on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic check_field(input string field, input logic [RATE_W-1:0] want,
                               input logic [RATE_W-1:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch %s: expected %0h, got %0h", field, want, got);
            end
        end
    endtask

    // Compare each result transfer with the oldest expected one
    always @(posedge i_clk) begin : result_check
        t_click_result got;
        t_click_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result %h", m_axis_tdata);
                end
            end else begin
                want = expected_results.pop_front();
                check_field("press_event", RATE_W'(want.press_event),
                            RATE_W'(got.press_event));
                check_field("release_event", RATE_W'(want.release_event),
                            RATE_W'(got.release_event));
                check_field("button_held", RATE_W'(want.button_held),
                            RATE_W'(got.button_held));
                check_field("move_valid", RATE_W'(want.move_valid),
                            RATE_W'(got.move_valid));
                check_field("move_x", want.move_x, got.move_x);
                check_field("move_y", want.move_y, got.move_y);
            end
        end
    end

    task automatic reset_model();
        for (int ch = 0; ch < CHANNELS; ch++) begin
            avg_model[ch] = AVG_RESET;
        end
        hold_model = '0;
        ratio_cfg  = RATIO_RST;
        weight_cfg = WEIGHT_RST;
        gain_cfg   = GAIN_RST;
        hold_cfg   = HOLD_RST;
    endtask

    // Gain times rate, truncated toward zero
    function automatic logic [RATE_W-1:0] scale_rate(input logic [RATE_W-1:0] raw);
        logic [63:0] mag;
        logic [63:0] q;
        mag = raw[RATE_W-1] ? (64'h10000 - 64'(raw)) : 64'(raw);
        q = (mag * 64'(gain_cfg)) >> 16;
        if (raw[RATE_W-1]) begin
            q = -q;
        end
        return q[RATE_W-1:0];
    endfunction

    // Threshold test, average update, hold counter and cursor for one frame
    function automatic t_click_result predict_click(input t_frame f);
        t_click_result r;
        logic [63:0]   sum;
        logic [63:0]   avg;
        logic [63:0]   limit;
        logic          active;
        r = '0;
        active = 1'b1;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            sum = 64'(f.samples[ch][0]) + 64'(f.samples[ch][1]);
            avg = 64'(avg_model[ch]);
            limit = avg * 64'(ratio_cfg);
            if ((sum << SUM_FRAC) < limit) begin
                active = 1'b0;
            end
            avg = ((avg * (64'd65536 - 64'(weight_cfg))) >> 16) + sum * 64'(weight_cfg);
            avg_model[ch] = avg[AVG_W-1:0];
        end
        if (active && hold_model == 0) begin
            r.press_event = 1'b1;
            hold_model = hold_cfg;
        end else if (!active && hold_model != 0) begin
            hold_model = hold_model - HOLD_W'(1);
            r.release_event = (hold_model == 0);
        end
        r.button_held = (hold_model != 0);
        r.move_y      = scale_rate(f.pitch);
        r.move_x      = scale_rate(f.yaw);
        r.move_valid  = (r.move_x != 0) || (r.move_y != 0);
        return r;
    endfunction

    // Smallest channel sum that still reaches the threshold
    function automatic int pass_sum(input int ch);
        logic [63:0] t;
        t = 64'(avg_model[ch]) * 64'(ratio_cfg);
        t = (t + 64'((1 << SUM_FRAC) - 1)) >> SUM_FRAC;
        if (t > 64'(MAX_SUM)) begin
            t = 64'(MAX_SUM);
        end
        return int'(t);
    endfunction

    function automatic int quiet_sum(input int ch);
        int need;
        int s;
        need = pass_sum(ch);
        s = $urandom_range(3000, 500);
        if (need > 0 && s >= need) begin
            s = need - 1;
        end
        return s;
    endfunction

    // Split a channel sum into two samples at random
    function automatic void set_sum(inout t_frame f, input int ch, input int sum);
        int lo;
        int hi;
        int a;
        lo = (sum > 65535) ? sum - 65535 : 0;
        hi = (sum < 65535) ? sum : 65535;
        a = $urandom_range(hi, lo);
        f.samples[ch][0] = SAMPLE_W'(a);
        f.samples[ch][1] = SAMPLE_W'(sum - a);
    endfunction

    function automatic logic [RATE_W-1:0] random_rate();
        int v;
        if ($urandom_range(4) == 0) begin
            v = $urandom_range(16);
            return RATE_W'(v - 8);
        end
        return RATE_W'($urandom);
    endfunction

    // Frame built against the current averages, so clicks and boundaries land where intended
    function automatic t_frame make_frame(input t_frame_kind kind);
        t_frame f;
        int     s;
        int     pick;
        f = '0;
        case (kind)
            FR_NOISE: begin
                f = {$urandom, $urandom, $urandom, $urandom, $urandom};
            end
            FR_QUIET: begin
                for (int ch = 0; ch < CHANNELS; ch++) set_sum(f, ch, quiet_sum(ch));
            end
            FR_BOUNDARY: begin
                for (int ch = 0; ch < CHANNELS; ch++) set_sum(f, ch, pass_sum(ch));
                if ($urandom_range(1) == 1) begin
                    pick = $urandom_range(CHANNELS - 1);
                    if (pass_sum(pick) > 0) set_sum(f, pick, pass_sum(pick) - 1);
                end
            end
            default: begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    s = pass_sum(ch) + $urandom_range(40000);
                    set_sum(f, ch, (s > MAX_SUM) ? MAX_SUM : s);
                end
                if (kind == FR_ONE_LOW) begin
                    pick = $urandom_range(CHANNELS - 1);
                    set_sum(f, pick, quiet_sum(pick));
                end
            end
        endcase
        if (kind != FR_NOISE) begin
            f.pitch = random_rate();
            f.yaw   = random_rate();
        end
        return f;
    endfunction

    // Input transfer with optional idle gap; expectation is formed on acceptance
    task automatic send_frame(input t_frame f);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_click(f));
        frames_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_RATIO:  ratio_cfg  = value[RATIO_W-1:0];
            CFG_WEIGHT: weight_cfg = value[WEIGHT_W-1:0];
            CFG_GAIN:   gain_cfg   = value[GAIN_W-1:0];
            CFG_HOLD:   hold_cfg   = value[HOLD_W-1:0];
        endcase
    endtask

    // Reset values: gyro extremes, zero and full samples, press then delayed release
    task automatic test_default_click();
        t_frame f;
        f = make_frame(FR_QUIET);
        f.samples = '0;
        f.pitch = 16'h8000;
        f.yaw   = 16'h7FFF;
        send_frame(f);
        f = make_frame(FR_QUIET);
        f.pitch = '0;
        f.yaw   = '0;
        send_frame(f);
        f = make_frame(FR_QUIET);
        f.pitch = 16'h7FFF;
        f.yaw   = 16'h8000;
        send_frame(f);
        f = make_frame(FR_CLICK);
        f.samples = '1;
        send_frame(f);
        repeat (3) send_frame(make_frame(FR_QUIET));
    endtask

    // Sums exactly at the threshold pass; one below on any channel blocks the click
    task automatic test_threshold_edge();
        t_frame f;
        f = make_frame(FR_QUIET);
        for (int k = 0; k < CHANNELS; k++) set_sum(f, k, pass_sum(k));
        send_frame(f);
        for (int ch = 0; ch < CHANNELS; ch++) begin
            f = make_frame(FR_QUIET);
            for (int k = 0; k < CHANNELS; k++) set_sum(f, k, pass_sum(k));
            set_sum(f, ch, pass_sum(ch) - 1);
            send_frame(f);
        end
    endtask

    task automatic test_cursor_gain();
        t_frame f;
        write_reg(CFG_GAIN, 16'hFFFF);
        f = make_frame(FR_QUIET);
        f.pitch = 16'h8000;
        f.yaw   = 16'h7FFF;
        send_frame(f);
        f = make_frame(FR_QUIET);
        f.pitch = 16'h0001;
        f.yaw   = 16'hFFFF;
        send_frame(f);
        write_reg(CFG_GAIN, 16'h0000);
        f = make_frame(FR_QUIET);
        f.pitch = 16'h8000;
        f.yaw   = 16'h7FFF;
        send_frame(f);
        write_reg(CFG_GAIN, GAIN_RST);
    endtask

    // Zero hold setting: every active frame presses, nothing is held; then ratio at its top
    task automatic test_hold_zero();
        write_reg(CFG_HOLD, 16'hFFF0);
        write_reg(CFG_RATIO, 16'h0000);
        repeat (3) send_frame(make_frame(FR_NOISE));
        write_reg(CFG_RATIO, 16'hFFFF);
        write_reg(CFG_HOLD, 16'h000F);
        send_frame(make_frame(FR_CLICK));
    endtask

    // Frozen averages with zero weight, then weights at and above one half
    task automatic test_weight_extremes();
        write_reg(CFG_RATIO, RATIO_RST);
        write_reg(CFG_HOLD, HOLD_RST);
        write_reg(CFG_WEIGHT, 16'h0000);
        send_frame(make_frame(FR_CLICK));
        send_frame(make_frame(FR_QUIET));
        write_reg(CFG_WEIGHT, 16'hFFFF);
        send_frame(make_frame(FR_CLICK));
        send_frame(make_frame(FR_QUIET));
        write_reg(CFG_WEIGHT, 16'h8000);
        send_frame(make_frame(FR_NOISE));
        write_reg(CFG_WEIGHT, WEIGHT_RST);
    endtask

    task automatic randomize_config();
        logic [CFG_DAT_W-1:0] v;
        case ($urandom_range(6))
            0:       v = 16'd0;
            1:       v = 16'd255;
            2:       v = 16'd256;
            3:       v = 16'd1023;
            4:       v = 16'hFFFF;
            default: v = CFG_DAT_W'($urandom_range(1023, 256));
        endcase
        write_reg(CFG_RATIO, v);
        case ($urandom_range(6))
            0:       v = 16'd0;
            1:       v = 16'd1;
            2:       v = 16'd32768;
            3:       v = 16'hFFFF;
            4:       v = WEIGHT_RST;
            default: v = CFG_DAT_W'($urandom_range(32768, 1));
        endcase
        write_reg(CFG_WEIGHT, v);
        case ($urandom_range(4))
            0:       v = 16'd0;
            1:       v = 16'hFFFF;
            2:       v = GAIN_RST;
            default: v = CFG_DAT_W'($urandom_range(65535));
        endcase
        write_reg(CFG_GAIN, v);
        case ($urandom_range(5))
            0:       v = 16'hFFF0;
            1:       v = 16'd1;
            2:       v = 16'd15;
            default: v = CFG_DAT_W'($urandom_range(15, 1));
        endcase
        write_reg(CFG_HOLD, v);
    endtask

    // Rest, optional noise, one to three click frames, then up to the hold setting plus two rest frames
    task automatic run_gesture();
        int          n;
        t_frame_kind kind;
        n = $urandom_range(4, 1);
        repeat (n) send_frame(make_frame(FR_QUIET));
        if ($urandom_range(3) == 0) send_frame(make_frame(FR_NOISE));
        n = $urandom_range(3, 1);
        repeat (n) begin
            case ($urandom_range(19))
                0, 1, 2: kind = FR_BOUNDARY;
                3, 4, 5: kind = FR_ONE_LOW;
                default: kind = FR_CLICK;
            endcase
            send_frame(make_frame(kind));
        end
        n = $urandom_range(int'(hold_cfg) + 2, 0);
        repeat (n) send_frame(make_frame(FR_QUIET));
    endtask

    task automatic test_random_gestures(input int sender_idle, input int receiver_stall,
                                        input int frames);
        int target;
        send_idle_pct = sender_idle;
        stall_pct     = receiver_stall;
        repeat (2) begin
            randomize_config();
            target = frames_sent + frames / 2;
            while (frames_sent < target) run_gesture();
        end
    endtask

    initial begin
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_click();
        test_threshold_edge();
        test_cursor_gain();
        test_hold_zero();
        test_weight_extremes();

        test_random_gestures(0, 0, PHASE_FRAMES);
        test_random_gestures(79, 0, PHASE_FRAMES);
        test_random_gestures(0, 79, PHASE_FRAMES);
        test_random_gestures(10, 10, PHASE_FRAMES);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
